// File: rtl/core/write_combine_region_manager_top_defines.svh
`ifndef WRITE_COMBINE_REGION_MANAGER_TOP_DEFINES_SVH
`define WRITE_COMBINE_REGION_MANAGER_TOP_DEFINES_SVH

// same-cycle implication
`define WCRM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wcrm assertion failed");

// next-cycle implication
`define WCRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wcrm assertion failed");

`endif

// File: rtl/core/wcrm_pkg.sv
package wcrm_pkg;

   localparam int REGION_SLOTS_DEF = 2;

   localparam logic [31:0] MIN_SIZE = 32'h0002_0000;

   // item commands
   localparam logic CMD_INIT = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   // cache types
   localparam logic [1:0] CT_NONCACHED = 2'd0;
   localparam logic [1:0] CT_CACHED    = 2'd1;
   localparam logic [1:0] CT_WC        = 2'd2;
   localparam logic [1:0] CT_OTHER     = 2'd3;

   // result status
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_NOT_SUP = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   typedef logic [3:0] op_type;

   // datapath operations
   localparam op_type OP_NONE      = 4'd0;
   localparam op_type OP_LOAD      = 4'd1;
   localparam op_type OP_ADOPT_LO  = 4'd2;
   localparam op_type OP_ADOPT_HI  = 4'd3;
   localparam op_type OP_SCAN_A    = 4'd4;
   localparam op_type OP_SCAN_B    = 4'd5;
   localparam op_type OP_MERGE     = 4'd6;
   localparam op_type OP_NEXT_SLOT = 4'd7;
   localparam op_type OP_ALLOC     = 4'd8;
   localparam op_type OP_NO_FREE   = 4'd9;
   localparam op_type OP_NOT_SUP   = 4'd10;
   localparam op_type OP_REBUILD   = 4'd11;
   localparam op_type OP_RESPOND   = 4'd12;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_init;
      logic is_wc;
      logic hit;
      logic merge_ok;
      logic new_legal;
      logic alloc_ok;
      logic last_slot;
   } dp_sts_type;

endpackage

// File: rtl/core/wcrm_datapath.sv
module wcrm_datapath #(
   parameter int REGION_SLOTS = wcrm_pkg::REGION_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wcrm_pkg::dp_cmd_type   cmd,
   output wcrm_pkg::dp_sts_type   sts,
   input  logic                   req_cmd,
   input  logic [31:0]            req_base_address,
   input  logic [31:0]            req_range_size,
   input  logic [1:0]             req_cache_type,
   input  logic [63:0]            req_firmware_image,
   output logic [1:0]             rsp_status,
   output logic [63:0]            rsp_register_image,
   output logic                   rsp_image_written
);

   localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

   function automatic logic legal_size(input logic [31:0] s);
      return (s >= wcrm_pkg::MIN_SIZE) && ((s & (s - 32'd1)) == 32'd0);
   endfunction

   function automatic logic [3:0] ctz15(input logic [14:0] m);
      logic [3:0] n;
      n = '0;
      for (int k = 14; k >= 0; k--) begin
         if (m[k]) n = 4'(k);
      end
      return n;
   endfunction

   // item registers
   logic              cmd_ff, cmd_in;
   logic [1:0]        ctype_ff, ctype_in;
   logic [31:0]       base_ff, base_in;
   logic [31:0]       size_ff, size_in;
   logic [31:0]       ne_ff, ne_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              hit_ff, hit_in;
   logic [31:0]       cb_ff, cb_in;
   logic [31:0]       cmax_ff, cmax_in;
   logic [31:0]       cs_ff, cs_in;
   logic [1:0]        status_ff, status_in;
   logic              wrote_ff, wrote_in;

   // region table and image
   logic [REGION_SLOTS-1:0] valid_ff, valid_in;
   logic [REGION_SLOTS-1:0] fw_ff, fw_in;
   logic [31:0]             ebase_ff [REGION_SLOTS];
   logic [31:0]             ebase_in [REGION_SLOTS];
   logic [31:0]             elen_ff [REGION_SLOTS];
   logic [31:0]             elen_in [REGION_SLOTS];
   logic [1:0]              riu_ff, riu_in;
   logic [63:0]             image_ff, image_in;

   // result registers
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_image_ff, rsp_image_in;
   logic        rsp_wrote_ff, rsp_wrote_in;

   // slot picker
   logic              pick_ok;
   logic [SLOT_W-1:0] pick_idx;

   always_comb begin
      pick_ok  = 1'b0;
      pick_idx = '0;
      for (int i = 0; i < REGION_SLOTS; i++) begin
         if (!pick_ok) begin
            if (riu_ff >= 2'd2 ? fw_ff[i] : !valid_ff[i]) begin
               pick_ok  = 1'b1;
               pick_idx = SLOT_W'(i);
            end
         end
      end
   end

   // half being adopted at init
   logic [31:0] adopt_half;
   logic [14:0] adopt_mask;
   logic        adopt_en;
   logic [31:0] adopt_len;

   assign adopt_half = (cmd.op == wcrm_pkg::OP_ADOPT_HI) ? image_ff[63:32] : image_ff[31:0];
   assign adopt_mask = adopt_half[16:2];
   assign adopt_en   = (adopt_half[1:0] == wcrm_pkg::CT_WC) && (adopt_mask != 15'd0);
   assign adopt_len  = wcrm_pkg::MIN_SIZE << ctz15(adopt_mask);

   // scan of the current slot
   logic [31:0] rb, re;
   assign rb = ebase_ff[slot_ff];
   assign re = rb + elen_ff[slot_ff];

   // image rebuild from the table
   logic [63:0] rebuilt;
   always_comb begin
      logic [1:0][31:0] half;
      logic [1:0]       used;
      logic [31:0]      neg;
      half[0] = {image_ff[31:2], 2'b00};
      half[1] = {image_ff[63:34], 2'b00};
      used    = '0;
      neg     = '0;
      for (int i = 0; i < REGION_SLOTS; i++) begin
         if (valid_ff[i] && (used < 2'd2)) begin
            neg = 32'd0 - elen_ff[i];
            half[used[0]] = {ebase_ff[i][31:17], neg[31:17], wcrm_pkg::CT_WC};
            used = used + 2'd1;
         end
      end
      rebuilt = {half[1], half[0]};
   end

   always_comb begin
      cmd_in        = cmd_ff;
      ctype_in      = ctype_ff;
      base_in       = base_ff;
      size_in       = size_ff;
      ne_in         = ne_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      cb_in         = cb_ff;
      cmax_in       = cmax_ff;
      cs_in         = cs_ff;
      status_in     = status_ff;
      wrote_in      = wrote_ff;
      valid_in      = valid_ff;
      fw_in         = fw_ff;
      ebase_in      = ebase_ff;
      elen_in       = elen_ff;
      riu_in        = riu_ff;
      image_in      = image_ff;
      rsp_status_in = rsp_status_ff;
      rsp_image_in  = rsp_image_ff;
      rsp_wrote_in  = rsp_wrote_ff;

      unique case (cmd.op)
         wcrm_pkg::OP_NONE: begin
         end
         wcrm_pkg::OP_LOAD: begin
            cmd_in   = req_cmd;
            ctype_in = req_cache_type;
            base_in  = req_base_address;
            size_in  = req_range_size;
            ne_in    = req_base_address + req_range_size;
            slot_in  = '0;
            wrote_in = 1'b0;
            if (req_cmd == wcrm_pkg::CMD_INIT) begin
               status_in = wcrm_pkg::ST_OK;
               valid_in  = '0;
               fw_in     = '0;
               riu_in    = '0;
               image_in  = req_firmware_image;
            end else begin
               case (req_cache_type)
                  wcrm_pkg::CT_CACHED: status_in = wcrm_pkg::ST_NOT_SUP;
                  wcrm_pkg::CT_OTHER:  status_in = wcrm_pkg::ST_INVALID;
                  default:             status_in = wcrm_pkg::ST_OK;
               endcase
            end
         end
         wcrm_pkg::OP_ADOPT_LO, wcrm_pkg::OP_ADOPT_HI: begin
            if (adopt_en && pick_ok) begin
               valid_in[pick_idx] = 1'b1;
               fw_in[pick_idx]    = 1'b1;
               ebase_in[pick_idx] = {adopt_half[31:17], 17'd0};
               elen_in[pick_idx]  = adopt_len;
               if (riu_ff < 2'd2) riu_in = riu_ff + 2'd1;
            end
         end
         wcrm_pkg::OP_SCAN_A: begin
            hit_in  = valid_ff[slot_ff] &&
                      (((rb >= base_ff) && (rb <= ne_ff)) || ((base_ff <= re) && (base_ff >= rb)));
            cb_in   = (rb < base_ff) ? rb : base_ff;
            cmax_in = (re > ne_ff) ? re : ne_ff;
         end
         wcrm_pkg::OP_SCAN_B: begin
            cs_in = cmax_ff - cb_ff;
         end
         wcrm_pkg::OP_MERGE: begin
            ebase_in[slot_ff] = cb_ff;
            elen_in[slot_ff]  = cs_ff;
            fw_in[slot_ff]    = 1'b0;
         end
         wcrm_pkg::OP_NEXT_SLOT: begin
            slot_in = slot_ff + SLOT_W'(1);
         end
         wcrm_pkg::OP_ALLOC: begin
            valid_in[pick_idx] = 1'b1;
            fw_in[pick_idx]    = 1'b0;
            ebase_in[pick_idx] = base_ff;
            elen_in[pick_idx]  = size_ff;
            if (riu_ff < 2'd2) riu_in = riu_ff + 2'd1;
         end
         wcrm_pkg::OP_NO_FREE: begin
            status_in = wcrm_pkg::ST_NO_FREE;
         end
         wcrm_pkg::OP_NOT_SUP: begin
            status_in = wcrm_pkg::ST_NOT_SUP;
         end
         wcrm_pkg::OP_REBUILD: begin
            image_in  = rebuilt;
            wrote_in  = 1'b1;
            status_in = wcrm_pkg::ST_OK;
         end
         wcrm_pkg::OP_RESPOND: begin
            rsp_status_in = status_ff;
            rsp_image_in  = image_ff;
            rsp_wrote_in  = wrote_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ctype_ff      <= ctype_in;
      base_ff       <= base_in;
      size_ff       <= size_in;
      ne_ff         <= ne_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      cb_ff         <= cb_in;
      cmax_ff       <= cmax_in;
      cs_ff         <= cs_in;
      status_ff     <= status_in;
      wrote_ff      <= wrote_in;
      ebase_ff      <= ebase_in;
      elen_ff       <= elen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_image_ff  <= rsp_image_in;
      rsp_wrote_ff  <= rsp_wrote_in;
      if (reset) begin
         valid_ff <= '0;
         fw_ff    <= '0;
         riu_ff   <= '0;
         image_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         fw_ff    <= fw_in;
         riu_ff   <= riu_in;
         image_ff <= image_in;
      end
   end

   assign sts.is_init   = (cmd_ff == wcrm_pkg::CMD_INIT);
   assign sts.is_wc     = (ctype_ff == wcrm_pkg::CT_WC);
   assign sts.hit       = hit_ff;
   assign sts.merge_ok  = legal_size(cs_ff) && ((cb_ff & (cs_ff - 32'd1)) == 32'd0);
   assign sts.new_legal = legal_size(size_ff) && ((base_ff & (size_ff - 32'd1)) == 32'd0);
   assign sts.alloc_ok  = pick_ok;
   assign sts.last_slot = (slot_ff == SLOT_W'(REGION_SLOTS - 1));

   assign rsp_status         = rsp_status_ff;
   assign rsp_register_image = rsp_image_ff;
   assign rsp_image_written  = rsp_wrote_ff;

endmodule

// File: rtl/core/wcrm_ctrl.sv
module wcrm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wcrm_pkg::dp_cmd_type cmd,
   input  wcrm_pkg::dp_sts_type sts
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_ADOPT_LO = 4'd2;
   localparam logic [3:0] S_ADOPT_HI = 4'd3;
   localparam logic [3:0] S_SCAN_A   = 4'd4;
   localparam logic [3:0] S_SCAN_B   = 4'd5;
   localparam logic [3:0] S_SCAN_C   = 4'd6;
   localparam logic [3:0] S_NEW_CHK  = 4'd7;
   localparam logic [3:0] S_ALLOC    = 4'd8;
   localparam logic [3:0] S_REBUILD  = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = wcrm_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = wcrm_pkg::OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_init)    state_in = S_ADOPT_LO;
            else if (sts.is_wc) state_in = S_SCAN_A;
            else                state_in = S_DONE;
         end
         S_ADOPT_LO: begin
            cmd.op   = wcrm_pkg::OP_ADOPT_LO;
            state_in = S_ADOPT_HI;
         end
         S_ADOPT_HI: begin
            cmd.op   = wcrm_pkg::OP_ADOPT_HI;
            state_in = S_DONE;
         end
         S_SCAN_A: begin
            cmd.op   = wcrm_pkg::OP_SCAN_A;
            state_in = S_SCAN_B;
         end
         S_SCAN_B: begin
            if (sts.hit) begin
               cmd.op   = wcrm_pkg::OP_SCAN_B;
               state_in = S_SCAN_C;
            end else if (sts.last_slot) begin
               state_in = S_NEW_CHK;
            end else begin
               cmd.op   = wcrm_pkg::OP_NEXT_SLOT;
               state_in = S_SCAN_A;
            end
         end
         S_SCAN_C: begin
            if (sts.merge_ok) begin
               cmd.op   = wcrm_pkg::OP_MERGE;
               state_in = S_REBUILD;
            end else if (sts.last_slot) begin
               state_in = S_NEW_CHK;
            end else begin
               cmd.op   = wcrm_pkg::OP_NEXT_SLOT;
               state_in = S_SCAN_A;
            end
         end
         S_NEW_CHK: begin
            if (sts.new_legal) begin
               state_in = S_ALLOC;
            end else begin
               cmd.op   = wcrm_pkg::OP_NOT_SUP;
               state_in = S_DONE;
            end
         end
         S_ALLOC: begin
            if (sts.alloc_ok) begin
               cmd.op   = wcrm_pkg::OP_ALLOC;
               state_in = S_REBUILD;
            end else begin
               cmd.op   = wcrm_pkg::OP_NO_FREE;
               state_in = S_DONE;
            end
         end
         S_REBUILD: begin
            cmd.op   = wcrm_pkg::OP_REBUILD;
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = wcrm_pkg::OP_RESPOND;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/write_combine_region_manager_top.sv
// Write-combine requests run up to two slot scans of up to 3 steps each, then a merge
// or a size check and allocation, and an image rebuild in the sequencer.
// Throughput: one item at a time; the next item is taken the cycle after a result
// is registered, even while that result is still stalled.
// Reset clears the region table valid and firmware bits, the usage count and image.
`include "write_combine_region_manager_top_defines.svh"

module write_combine_region_manager_top #(
   parameter int REGION_SLOTS = wcrm_pkg::REGION_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_base_address,
   input  logic [31:0] req_range_size,
   input  logic [1:0]  req_cache_type,
   input  logic [63:0] req_firmware_image,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_register_image,
   output logic        rsp_image_written
);

   wcrm_pkg::dp_cmd_type dp_cmd;
   wcrm_pkg::dp_sts_type dp_sts;

   wcrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   wcrm_datapath #(
      .REGION_SLOTS (REGION_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .sts                (dp_sts),
      .req_cmd            (req_cmd),
      .req_base_address   (req_base_address),
      .req_range_size     (req_range_size),
      .req_cache_type     (req_cache_type),
      .req_firmware_image (req_firmware_image),
      .rsp_status         (rsp_status),
      .rsp_register_image (rsp_register_image),
      .rsp_image_written  (rsp_image_written)
   );

   `WCRM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `WCRM_ASSERT_IMPL(a_no_result_overrun, clock, reset, dp_cmd.op == wcrm_pkg::OP_RESPOND, !rsp_valid || !rsp_stall)
   `WCRM_ASSERT_IMPL(a_written_is_ok, clock, reset, rsp_valid && rsp_image_written, rsp_status == wcrm_pkg::ST_OK)

endmodule
